/* rtl/dbsa_pkg.sv */
// Package for the direct block sector allocator: sizes, operation and status codes,
// item and result structs, and request structs for the two memories.
// No dependencies.
`default_nettype none

package dbsa_pkg;

  // Geometry
  localparam int SectorBytes = 128;
  localparam int SectShift   = 7;
  localparam int TblEntries  = 30;
  localparam int DiskSectors = 1024;
  localparam int WordBits    = 32;
  localparam int MapWords    = DiskSectors / WordBits;
  localparam int Capacity    = TblEntries * SectorBytes;

  // Widths
  localparam int SectW  = 10;
  localparam int WordAW = 5;
  localparam int BitW   = 5;
  localparam int TIdxW  = 5;
  localparam int FreeW  = 11;
  localparam int LenW   = 12;

  // Operation codes
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_EXTEND  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_LOOKUP  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_UNMARKED  = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] file_bytes;
    logic [15:0] added_bytes;
    logic [15:0] byte_offset;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  sector;
    logic [11:0] file_length;
    logic [4:0]  sector_count;
  } result_t;

  typedef struct packed {
    logic                rd_en;
    logic [WordAW-1:0]   rd_addr;
    logic                wr_en;
    logic [WordAW-1:0]   wr_addr;
    logic [WordBits-1:0] wr_data;
  } bm_req_t;

  typedef struct packed {
    logic             rd_en;
    logic [TIdxW-1:0] rd_addr;
    logic             wr_en;
    logic [TIdxW-1:0] wr_addr;
    logic [SectW-1:0] wr_data;
  } tbl_req_t;

endpackage

`default_nettype wire

/* rtl/dbsa_bitmap.sv */
// Free-sector bitmap memory, one word per row, with row valid bits so that
// reset reads as all free. Finds the lowest free bit of the word read.
// Depends on dbsa_pkg.
`default_nettype none

module dbsa_bitmap import dbsa_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bm_req_t             req_i,
  output logic [WordBits-1:0]      rd_data_o,
  output logic                     free_found_o,
  output logic [BitW-1:0]          free_bit_o
);

  logic [WordBits-1:0] mem_q [MapWords];
  logic [WordBits-1:0] rd_q;
  logic [MapWords-1:0] vld_q;
  logic                rd_vld_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  // Track written rows; an unwritten row reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

  // Pick the lowest clear bit
  always_comb begin
    free_found_o = 1'b0;
    free_bit_o   = '0;
    for (int k = WordBits - 1; k >= 0; k--) begin
      if (!rd_data_o[k]) begin
        free_found_o = 1'b1;
        free_bit_o   = BitW'(k);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/dbsa_table.sv */
// Direct sector pointer table memory with a registered read port.
// Depends on dbsa_pkg.
`default_nettype none

module dbsa_table import dbsa_pkg::*; (
  input  wire logic         clk_i,
  input  wire tbl_req_t     req_i,
  output logic [SectW-1:0]  rd_data_o
);

  logic [SectW-1:0] mem_q [TblEntries];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/direct_block_sector_allocator_unit.sv */
// Top level of the direct block sector allocator: control sequencer around
// the bitmap and pointer table memories. Depends on dbsa_pkg, dbsa_bitmap, dbsa_table.
//
// Usage: drive item_i and raise start while busy is low; the item is taken at
// that edge and busy rises on the next cycle. Exactly one result per item
// appears on result_o for one cycle with result_valid_o high, and busy has
// dropped by then; the receiver cannot stall, so it must take the result then.
// Steps per item, through the registered memory reads:
//   create/extend: per sector claimed, bitmap words are read in turn, full ones
//   skipped (the scan restarts at word 0 for every item, so up to 31 full words
//   may be skipped), then the bit and table entry written; lookup: a table read
//   if in range; release: per listed sector a table read, a bitmap read, a clear.
// One item is in work at a time; a new item may start in the result cycle.
// Reset: the bitmap reads as all free at once (row valid bits, no sweep),
// the free count is 1024, the file is empty. The table needs no clearing
// because only entries below the sector count are ever read.
`default_nettype none

module direct_block_sector_allocator_unit import dbsa_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire item_t   item_i,
  output logic         result_valid_o,
  output result_t      result_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CL_RD, S_CL_CHK, S_RL_TRD, S_RL_BRD, S_RL_MOD, S_LK_WAIT, S_FIN
  } state_e;

  state_e              state_q, state_d;
  item_t               item_q, item_d;
  logic [FreeW-1:0]    free_q, free_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [TIdxW-1:0]    used_q, used_d;
  logic [WordAW-1:0]   ptr_q, ptr_d;
  logic [TIdxW-1:0]    idx_q, idx_d;
  logic [TIdxW-1:0]    left_q, left_d;
  logic [SectW-1:0]    sec_q, sec_d;
  logic [SectW-1:0]    rel_q, rel_d;
  logic [2:0]          status_q, status_d;
  result_t             res_q, res_d;
  logic                res_vld_q, res_vld_d;

  bm_req_t             bm_req;
  tbl_req_t            tbl_req;
  logic [WordBits-1:0] bm_data;
  logic                bm_found;
  logic [BitW-1:0]     bm_bit;
  logic [SectW-1:0]    tbl_data;

  // Decision arithmetic
  logic              too_big;
  logic [16:0]       sum_c;
  logic [9:0]        need_c;
  logic              fresh;
  logic [TIdxW-1:0]  base;
  logic [LenW-1:0]   base_bytes;
  logic [17:0]       t_ext;
  logic [17:0]       t_rnd;
  logic              pos;
  logic [10:0]       more;
  logic [11:0]       total;
  logic [11:0]       claims;
  logic [15:0]       ext_sum;
  logic [8:0]        lk_idx;

  dbsa_bitmap u_bitmap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (bm_req),
    .rd_data_o    (bm_data),
    .free_found_o (bm_found),
    .free_bit_o   (bm_bit)
  );

  dbsa_table u_table (
    .clk_i     (clk_i),
    .req_i     (tbl_req),
    .rd_data_o (tbl_data)
  );

  // Size checks and sector demand
  always_comb begin
    too_big    = item_q.file_bytes > 16'(Capacity);
    sum_c      = {1'b0, item_q.file_bytes} + 17'(SectorBytes - 1);
    need_c     = sum_c[16:SectShift];
    fresh      = (item_q.file_bytes == '0) && (item_q.added_bytes != '0);
    base       = fresh ? TIdxW'(1) : used_q;
    base_bytes = LenW'(base) << SectShift;
    t_ext      = {2'b00, item_q.added_bytes} + {2'b00, item_q.file_bytes}
                 - {6'd0, base_bytes};
    pos        = !t_ext[17] && (t_ext != '0);
    t_rnd      = t_ext + 18'(SectorBytes - 1);
    more       = pos ? t_rnd[17:SectShift] : '0;
    total      = 12'(base) + 12'(more);
    claims     = 12'(more) + 12'(fresh);
    ext_sum    = item_q.file_bytes + item_q.added_bytes;
    lk_idx     = item_q.byte_offset[15:SectShift];
  end

  // Sequencer next state and memory requests
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    free_d    = free_q;
    len_d     = len_q;
    used_d    = used_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    left_d    = left_q;
    sec_d     = sec_q;
    rel_d     = rel_q;
    status_d  = status_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    bm_req    = '0;
    tbl_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d   = item_i;
          status_d = ST_OK;
          sec_d    = '0;
          ptr_d    = '0;
          state_d  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_d = S_FIN;
        case (item_q.operation)
          OP_CREATE: begin
            if (too_big) begin
              status_d = ST_TOO_LARGE;
            end else if ({1'b0, free_q} < {2'b00, need_c}) begin
              status_d = ST_NO_SPACE;
            end else begin
              used_d = need_c[TIdxW-1:0];
              len_d  = item_q.file_bytes[LenW-1:0];
              idx_d  = '0;
              left_d = need_c[TIdxW-1:0];
              if (need_c != '0) begin
                state_d = S_CL_RD;
              end
            end
          end
          OP_EXTEND: begin
            if (too_big || (total > 12'(TblEntries))) begin
              status_d = ST_TOO_LARGE;
            end else if ({1'b0, free_q} < claims) begin
              status_d = ST_NO_SPACE;
            end else begin
              used_d = total[TIdxW-1:0];
              len_d  = ext_sum[LenW-1:0];
              idx_d  = fresh ? '0 : used_q;
              left_d = claims[TIdxW-1:0];
              if (claims != '0) begin
                state_d = S_CL_RD;
              end
            end
          end
          OP_RELEASE: begin
            idx_d = '0;
            if (used_q != '0) begin
              state_d = S_RL_TRD;
            end
          end
          default: begin
            if (9'(used_q) <= lk_idx) begin
              status_d = ST_OUTSIDE;
            end else begin
              tbl_req.rd_en   = 1'b1;
              tbl_req.rd_addr = lk_idx[TIdxW-1:0];
              state_d         = S_LK_WAIT;
            end
          end
        endcase
      end

      // Claim: read the current bitmap word
      S_CL_RD: begin
        bm_req.rd_en   = 1'b1;
        bm_req.rd_addr = ptr_q;
        state_d        = S_CL_CHK;
      end

      // Claim: take the lowest free bit or advance to the next word
      S_CL_CHK: begin
        if (!bm_found) begin
          ptr_d   = ptr_q + 1'b1;
          state_d = S_CL_RD;
        end else begin
          bm_req.wr_en    = 1'b1;
          bm_req.wr_addr  = ptr_q;
          bm_req.wr_data  = bm_data | (WordBits'(1) << bm_bit);
          tbl_req.wr_en   = 1'b1;
          tbl_req.wr_addr = idx_q;
          tbl_req.wr_data = {ptr_q, bm_bit};
          free_d          = free_q - 1'b1;
          idx_d           = idx_q + 1'b1;
          left_d          = left_q - 1'b1;
          state_d         = (left_q == TIdxW'(1)) ? S_FIN : S_CL_RD;
        end
      end

      // Release: fetch the listed sector
      S_RL_TRD: begin
        tbl_req.rd_en   = 1'b1;
        tbl_req.rd_addr = idx_q;
        state_d         = S_RL_BRD;
      end

      // Release: fetch the bitmap word holding it
      S_RL_BRD: begin
        rel_d          = tbl_data;
        bm_req.rd_en   = 1'b1;
        bm_req.rd_addr = tbl_data[SectW-1:BitW];
        state_d        = S_RL_MOD;
      end

      // Release: clear the bit, or flag it when already clear
      S_RL_MOD: begin
        if (bm_data[rel_q[BitW-1:0]]) begin
          bm_req.wr_en   = 1'b1;
          bm_req.wr_addr = rel_q[SectW-1:BitW];
          bm_req.wr_data = bm_data & ~(WordBits'(1) << rel_q[BitW-1:0]);
          free_d         = free_q + 1'b1;
        end else begin
          status_d = ST_UNMARKED;
        end
        idx_d   = idx_q + 1'b1;
        state_d = ((idx_q + 1'b1) == used_q) ? S_FIN : S_RL_TRD;
      end

      S_LK_WAIT: begin
        sec_d   = tbl_data;
        state_d = S_FIN;
      end

      // Present the result for one cycle
      S_FIN: begin
        res_vld_d          = 1'b1;
        res_d.status       = status_q;
        res_d.sector       = sec_q;
        res_d.file_length  = len_q;
        res_d.sector_count = used_q;
        state_d            = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      free_q    <= FreeW'(DiskSectors);
      len_q     <= '0;
      used_q    <= '0;
      ptr_q     <= '0;
      idx_q     <= '0;
      left_q    <= '0;
      status_q  <= ST_OK;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      free_q    <= free_d;
      len_q     <= len_d;
      used_q    <= used_d;
      ptr_q     <= ptr_d;
      idx_q     <= idx_d;
      left_q    <= left_d;
      status_q  <= status_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    sec_q  <= sec_d;
    rel_q  <= rel_d;
    res_q  <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

`ifndef NO_ASSERTIONS
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FreeW'(DiskSectors))
    else $error("free count above disk size");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= TIdxW'(TblEntries))
    else $error("sector count above table size");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_claim_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CL_CHK) |-> (free_q != '0))
    else $error("claim attempted with no free sector");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_FIN))
    else $error("result strobe without finishing step");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench for direct_block_sector_allocator_unit: directed and random items,
// checked field by field against an in-bench allocator predictor.
// Depends on dbsa_pkg and the RTL of the unit.
`default_nettype none

module testbench;
  import dbsa_pkg::*;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  logic    result_valid_o;
  result_t result_o;

  // Predictor state
  bit          sect_used[DiskSectors];
  int unsigned free_left;
  int unsigned ptr_table[TblEntries];
  int unsigned file_len;
  int unsigned file_sects;

  result_t pending_results[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  bit      quiet_sender = 1'b0;
  int      op_hits[4];

  direct_block_sector_allocator_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned grab_lowest_free();
    for (int s = 0; s < DiskSectors; s++) begin
      if (!sect_used[s]) begin
        sect_used[s] = 1'b1;
        if (free_left > 0) free_left--;
        return s;
      end
    end
    return 0;
  endfunction

  // Work out the result of one item and update the predicted state
  function automatic result_t allocate_step(item_t it);
    result_t r;
    int fsize, added, need, more, base;
    int unsigned idx;
    bit fresh;
    fsize = it.file_bytes;
    added = it.added_bytes;
    r = '0;
    r.status = ST_OK;
    case (it.operation)
      OP_CREATE: begin
        need = (fsize + SectorBytes - 1) / SectorBytes;
        if (fsize > Capacity || need > TblEntries) r.status = ST_TOO_LARGE;
        else if (free_left < need) r.status = ST_NO_SPACE;
        else begin
          for (int i = 0; i < need; i++) ptr_table[i] = grab_lowest_free();
          file_sects = need;
          file_len = fsize;
        end
      end
      OP_EXTEND: begin
        if (fsize > Capacity) r.status = ST_TOO_LARGE;
        else begin
          fresh = (fsize == 0 && added > 0);
          base = fresh ? 1 : file_sects;
          need = added - (base * SectorBytes - fsize);
          more = 0;
          if (need > 0) more = (need + SectorBytes - 1) / SectorBytes;
          if (base + more > TblEntries) r.status = ST_TOO_LARGE;
          else if (int'(free_left) < more + (fresh ? 1 : 0)) r.status = ST_NO_SPACE;
          else begin
            if (fresh) ptr_table[0] = grab_lowest_free();
            for (int i = 0; i < more; i++) ptr_table[base + i] = grab_lowest_free();
            file_sects = base + more;
            file_len = fsize + added;
          end
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < file_sects && i < TblEntries; i++) begin
          if (ptr_table[i] >= DiskSectors || !sect_used[ptr_table[i]]) r.status = ST_UNMARKED;
          else begin
            sect_used[ptr_table[i]] = 1'b0;
            free_left++;
          end
        end
      end
      default: begin
        idx = it.byte_offset / SectorBytes;
        if (idx >= file_sects || idx >= TblEntries) r.status = ST_OUTSIDE;
        else r.sector = 10'(ptr_table[idx]);
      end
    endcase
    r.file_length = 12'(file_len);
    r.sector_count = 5'(file_sects);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status)
          report_mismatch("status", result_o.status, want.status);
        if (result_o.sector !== want.sector)
          report_mismatch("sector", result_o.sector, want.sector);
        if (result_o.file_length !== want.file_length)
          report_mismatch("file_length", result_o.file_length, want.file_length);
        if (result_o.sector_count !== want.sector_count)
          report_mismatch("sector_count", result_o.sector_count, want.sector_count);
      end
    end
  end

  // Send one item: random gap unless quiet_sender is set, then hold start until accepted
  task automatic send_item(logic [1:0] op, int fb, int ab, int off);
    item_t it;
    it.operation = op;
    it.file_bytes = 16'(fb);
    it.added_bytes = 16'(ab);
    it.byte_offset = 16'(off);
    // Keep start low until the next falling edge after the previous item
    @(negedge clk_i);
    if (!quiet_sender) begin
      while ($urandom_range(99) < 16) @(negedge clk_i);
    end
    item_i <= it;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(allocate_step(it));
    op_hits[op]++;
    items_sent++;
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(OP_LOOKUP, 0, 0, 0);
    send_item(OP_RELEASE, 0, 0, 0);
    send_item(OP_CREATE, 0, 0, 0);
    send_item(OP_CREATE, 65535, 65535, 65535);
    send_item(OP_CREATE, Capacity + 1, 0, 0);
    send_item(OP_CREATE, Capacity, 0, 0);
    send_item(OP_LOOKUP, 0, 0, 0);
    send_item(OP_LOOKUP, 0, 0, Capacity - 1);
    send_item(OP_LOOKUP, 0, 0, Capacity);
    send_item(OP_LOOKUP, 0, 0, 65535);
    send_item(OP_EXTEND, Capacity, 1, 0);
    send_item(OP_RELEASE, 0, 0, 0);
    send_item(OP_RELEASE, 0, 0, 0);
    send_item(OP_EXTEND, 0, 200, 0);
    send_item(OP_EXTEND, 200, 0, 0);
    send_item(OP_EXTEND, 200, 56, 0);
    send_item(OP_EXTEND, 256, 3000, 0);
    send_item(OP_EXTEND, 65535, 0, 0);
    send_item(OP_EXTEND, 0, 0, 0);
    send_item(OP_LOOKUP, 0, 0, 129);
    send_item(OP_RELEASE, 0, 0, 0);
  endtask

  // Fill the disk with abandoned creates until space runs out
  task automatic test_exhaustion();
    for (int i = 0; i < 40; i++) send_item(OP_CREATE, Capacity, 0, 0);
    send_item(OP_EXTEND, 0, 1, 0);
    send_item(OP_CREATE, 1, 0, 0);
    send_item(OP_RELEASE, 0, 0, 0);
    send_item(OP_EXTEND, 0, 65535, 0);
  endtask

  // Random mix, mostly create/extend/lookup on the live file
  task automatic test_random(int n);
    int fb, ab, off;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      quiet_sender = (i >= n / 3 && i < n / 2);
      op = 2'($urandom_range(3));
      case ($urandom_range(9))
        0: begin fb = $urandom_range(65535); ab = $urandom_range(65535); end
        1, 2: begin fb = file_len; ab = $urandom_range(400); end
        3: begin fb = $urandom_range(Capacity); ab = $urandom_range(Capacity); end
        default: begin fb = $urandom_range(1200); ab = $urandom_range(300); end
      endcase
      off = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                     : $urandom_range(file_sects * SectorBytes + 64);
      send_item(op, fb, ab, off);
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    int waited;
    foreach (sect_used[s]) sect_used[s] = 1'b0;
    foreach (ptr_table[i]) ptr_table[i] = 0;
    free_left = DiskSectors;
    file_len = 0;
    file_sects = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_exhaustion();
    test_random(900);
    waited = 0;
    while (pending_results.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (200) @(posedge clk_i);
    if (pending_results.size() != 0) report_mismatch("results left over", 
      pending_results.size(), 0);
    $display("ran %0d items (create %0d, extend %0d, release %0d, lookup %0d), %0d results",
             items_sent, op_hits[0], op_hits[1], op_hits[2], op_hits[3], results_seen);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Overall watchdog
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end
endmodule

`default_nettype wire

/* direct_block_sector_allocator_unit.f */
rtl/dbsa_pkg.sv
rtl/dbsa_bitmap.sv
rtl/dbsa_table.sv
rtl/direct_block_sector_allocator_unit.sv
tb/testbench.sv
